>>> rtl/whl_pkg.sv
// ----------------------------------------------------------------------------
// whl_pkg: shared types and constants of the weighted log histogram
// Payload structs, register indexes, result status codes, controller
// states and the command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package whl_pkg;

   localparam int MAX_BINS_DEF  = 256;
   localparam int NUM_SNAPS_DEF = 16;
   localparam int FRAC_BITS_DEF = 16;

   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_LOG_MODE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BINS_PER_MAG = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_INDEX    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_BINS     = 2'd3;

   localparam logic [1:0] STATUS_ACC      = 2'd0;
   localparam logic [1:0] STATUS_NEG_PROP = 2'd1;
   localparam logic [1:0] STATUS_RANGE    = 2'd2;
   localparam logic [1:0] STATUS_READ     = 2'd3;

   // log10(2) in Q32
   localparam logic signed [32:0] LOG10_2_Q32 = 33'sd1292913986;
   localparam int LOG_FRAC = 24;

   localparam logic [4:0] NORM_LAST = 5'd4;   // five binary-search steps
   localparam logic [4:0] SQR_LAST  = 5'd23;  // 24 squaring steps

   typedef struct packed {
      logic               func;
      logic [3:0]         snap;
      logic signed [31:0] bin_value;
      logic signed [31:0] prop_value;
      logic [31:0]        weight;
      logic [7:0]         read_bin;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  bin_index;
      logic [47:0] sum_out;
      logic [31:0] count_out;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DISP, ST_NORM, ST_SQR,
      ST_ML10, ST_MBPM, ST_BIN, ST_MEMRD, ST_UPD
   } state_type;

   typedef enum logic [1:0] {
      MUL_L10, MUL_BPM_LOG, MUL_BPM_LIN, MUL_WP
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        clr_wr;
      logic        norm;
      logic        sqr;
      logic [4:0]  step;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        bin;
      logic        mem_rd;
      logic        upd;
   } cmd_type;

   typedef struct packed {
      logic is_read;
      logic log_mode;
      logic bv_pos;
      logic bin_bad;
      logic clr_last;
   } stat_type;

endpackage

>>> rtl/weighted_log_histogram_top.sv
// ----------------------------------------------------------------------------
// weighted_log_histogram_top: per-snapshot weighted histogram, log or linear
// Accumulates weight*property and integer weight into one bin per object,
// and reads back single bins.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (req_valid/req_stall/req_data) carries one item per transfer:
//    func 0 accumulates an object, func 1 reads one bin of one snapshot.
//  - rsp channel returns exactly one result per item, in order.
//  - csr port writes log_mode, bins_per_mag, min_index, num_bins; write it
//    only while the block is idle.
// Steps, one item at a time (transfer to result valid):
//  - read: dispatch, bin, store read, update. Linear accumulate: dispatch,
//    bins_per_mag multiply, bin, store read, update. Log accumulate with a
//    positive value: dispatch, the 5-step normalizer, the 24-step log2
//    squaring loop, log10 multiply, bins_per_mag multiply, bin, store read,
//    update. Log accumulate with value <= 0: dispatch, bin, store read,
//    update. An item whose bin is out of range skips the store read.
//  - a new item is taken only in idle, which follows the last item's update.
//  - the result leaves through an output register, so the next item is
//    taken while a finished result still waits on rsp_stall.
// Reset: a clearing pass zeroes all MAX_BINS*NUM_SNAPS addresses of both
// stores (4096 by default); req_stall stays high until it ends.
// A stalled result holds; the controller waits in its update step for a
// free output register before writing the store.
// ----------------------------------------------------------------------------
module weighted_log_histogram_top #(
   parameter int MAX_BINS  = whl_pkg::MAX_BINS_DEF,
   parameter int NUM_SNAPS = whl_pkg::NUM_SNAPS_DEF,
   parameter int FRAC_BITS = whl_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  whl_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output whl_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [whl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [whl_pkg::CSR_W-1:0]     csr_wdata
);

   whl_pkg::cmd_type  cmd;
   whl_pkg::stat_type stat;

   // sequencing and handshakes
   whl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // arithmetic, registers and stores
   whl_datapath #(
      .MAX_BINS  (MAX_BINS),
      .NUM_SNAPS (NUM_SNAPS),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

   // one item at a time: after a transfer the input side closes
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted while an item is in progress");

   // the clearing pass holds off input right after reset
   a_clear_pass: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("input open during clearing pass");

   // a result is never produced while an item is still being taken in
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !cmd.upd)
      else $error("result written in the cycle after a transfer");

endmodule

>>> rtl/whl_datapath.sv
// ----------------------------------------------------------------------------
// whl_datapath: arithmetic, configuration and bin stores
// Normalizer, log2 squaring loop, shared multiplier, bin calculation and the
// sum/count memories with their saturating update.
// ----------------------------------------------------------------------------
module whl_datapath #(
   parameter int MAX_BINS  = whl_pkg::MAX_BINS_DEF,
   parameter int NUM_SNAPS = whl_pkg::NUM_SNAPS_DEF,
   parameter int FRAC_BITS = whl_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [whl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [whl_pkg::CSR_W-1:0]     csr_wdata,
   input  whl_pkg::req_type              req_data,
   output whl_pkg::rsp_type              rsp_data,
   input  whl_pkg::cmd_type              cmd,
   output whl_pkg::stat_type             stat
);

   localparam int DEPTH  = MAX_BINS * NUM_SNAPS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int BIN_W  = $clog2(MAX_BINS);

   // configuration
   logic               log_mode_ff;
   logic [10:0]        bpm_ff;
   logic signed [15:0] min_index_ff;
   logic [8:0]         num_bins_ff;
   logic [10:0]        bpm;

   always_ff @(posedge clock) begin
      if (reset) begin
         log_mode_ff  <= 1'b1;
         bpm_ff       <= 11'd10;
         min_index_ff <= 16'sd0;
         num_bins_ff  <= 9'd256;
      end else if (csr_we) begin
         unique case (csr_index)
            whl_pkg::CSR_LOG_MODE:     log_mode_ff  <= csr_wdata[0];
            whl_pkg::CSR_BINS_PER_MAG: bpm_ff       <= csr_wdata[10:0];
            whl_pkg::CSR_MIN_INDEX:    min_index_ff <= $signed(csr_wdata);
            whl_pkg::CSR_NUM_BINS:     num_bins_ff  <= csr_wdata[8:0];
         endcase
      end
   end

   assign bpm = (bpm_ff == 11'd0) ? 11'd1 : bpm_ff;

   // input item
   whl_pkg::req_type req_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
   end

   // normalize and square
   logic [31:0]        m_ff;
   logic [4:0]         msb_ff;
   logic [23:0]        frac_ff;
   logic [4:0]         sh;
   logic               top_zero;
   logic [30:0]        mant;
   logic [61:0]        sq_prod;
   logic [31:0]        sq_q;
   logic [30:0]        sq_next;
   logic signed [31:0] int_part;
   logic signed [31:0] lg2;

   assign sh       = 5'(16 >> cmd.step);
   assign top_zero = (m_ff >> (6'd32 - {1'b0, sh})) == 32'd0;
   assign mant     = m_ff[31:1];
   assign sq_prod  = 62'(mant) * 62'(mant);
   assign sq_q     = sq_prod[61:30];
   assign sq_next  = sq_q[31] ? sq_q[31:1] : sq_q[30:0];
   assign int_part = $signed({27'd0, msb_ff}) - 32'(FRAC_BITS);
   assign lg2      = (int_part <<< whl_pkg::LOG_FRAC) + $signed({8'd0, frac_ff});

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         m_ff   <= req_data.bin_value;
         msb_ff <= 5'd31;
      end else if (cmd.norm) begin
         if (top_zero) begin
            m_ff   <= m_ff << sh;
            msb_ff <= msb_ff - sh;
         end
      end else if (cmd.sqr) begin
         m_ff    <= {sq_next, 1'b0};
         frac_ff <= {frac_ff[22:0], sq_q[31]};
      end
   end

   // shared multiplier
   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [65:0] mul_p;
   logic signed [65:0] prod_ff;

   always_comb begin
      case (cmd.mul_sel)
         whl_pkg::MUL_L10: begin
            mul_a = {lg2[31], lg2};
            mul_b = whl_pkg::LOG10_2_Q32;
         end
         whl_pkg::MUL_BPM_LOG: begin
            mul_a = $signed(prod_ff[64:32]);
            mul_b = $signed({22'd0, bpm});
         end
         whl_pkg::MUL_BPM_LIN: begin
            mul_a = {req_ff.bin_value[31], req_ff.bin_value};
            mul_b = $signed({22'd0, bpm});
         end
         default: begin
            mul_a = $signed({1'b0, req_ff.weight});
            mul_b = {req_ff.prop_value[31], req_ff.prop_value};
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= mul_p;
      end
   end

   // bin calculation
   logic signed [39:0] raw;
   logic signed [40:0] bin_full;
   logic signed [40:0] bin_c;
   logic               bv_pos;
   logic               snap_bad;
   logic               acc_bad;
   logic               rd_bad;
   logic               bad;
   logic [15:0]        rb16;
   logic [BIN_W-1:0]   bin_sel;
   logic [ADDR_W-1:0]  addr;
   logic [ADDR_W-1:0]  addr_ff;
   logic [7:0]         idx8_ff;
   logic               bad_ff;

   assign bv_pos = req_ff.bin_value > 32'sd0;
   assign raw    = log_mode_ff ? $signed(prod_ff[63:24])
                               : $signed(prod_ff[FRAC_BITS+39:FRAC_BITS]);

   always_comb begin
      if (log_mode_ff && !bv_pos) begin
         bin_full = 41'sd0;
      end else begin
         bin_full = {raw[39], raw} - {{25{min_index_ff[15]}}, min_index_ff};
      end
      bin_c = (log_mode_ff && bin_full < 41'sd0) ? 41'sd0 : bin_full;
   end

   assign snap_bad = {5'd0, req_ff.snap} >= 9'(NUM_SNAPS);
   assign acc_bad  = (bin_c < 41'sd0) || (bin_c >= $signed({32'd0, num_bins_ff}))
                     || (bin_c >= $signed(41'(MAX_BINS))) || snap_bad;
   assign rd_bad   = ({5'd0, req_ff.read_bin} >= 13'(MAX_BINS)) || snap_bad;
   assign bad      = req_ff.func ? rd_bad : acc_bad;
   assign rb16     = 16'(req_ff.read_bin);
   assign bin_sel  = req_ff.func ? rb16[BIN_W-1:0] : bin_c[BIN_W-1:0];
   assign addr     = ADDR_W'(bin_sel) * ADDR_W'(NUM_SNAPS) + ADDR_W'(req_ff.snap);

   always_ff @(posedge clock) begin
      if (cmd.bin) begin
         addr_ff <= addr;
         idx8_ff <= req_ff.func ? req_ff.read_bin : bin_c[7:0];
         bad_ff  <= bad;
      end
   end

   // stores and clearing pass
   logic [47:0]       sum_mem [DEPTH];
   logic [31:0]       cnt_mem [DEPTH];
   logic [47:0]       rd_sum_ff;
   logic [31:0]       rd_cnt_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic              pv_neg;
   logic              upd_wr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [66:0]       sum_total;
   logic [47:0]       sum_new;
   logic [32:0]       cnt_total;
   logic [31:0]       cnt_new;

   assign pv_neg    = req_ff.prop_value[31];
   assign sum_total = 67'(rd_sum_ff) + 67'(prod_ff[65:FRAC_BITS]);
   assign sum_new   = (sum_total[66:48] != '0) ? '1 : sum_total[47:0];
   assign cnt_total = 33'(rd_cnt_ff) + 33'(req_ff.weight >> FRAC_BITS);
   assign cnt_new   = cnt_total[32] ? '1 : cnt_total[31:0];
   assign upd_wr    = cmd.upd && !req_ff.func && !bad_ff && !pv_neg;
   assign wr_en     = cmd.clr_wr || upd_wr;
   assign wr_addr   = cmd.clr_wr ? clr_addr_ff : addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sum_mem[wr_addr] <= cmd.clr_wr ? 48'd0 : sum_new;
         cnt_mem[wr_addr] <= cmd.clr_wr ? 32'd0 : cnt_new;
      end
      if (cmd.mem_rd) begin
         rd_sum_ff <= sum_mem[addr_ff];
         rd_cnt_ff <= cnt_mem[addr_ff];
      end
   end

   // result register
   whl_pkg::rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (cmd.upd) begin
         if (bad_ff) begin
            rsp_ff.status    <= whl_pkg::STATUS_RANGE;
            rsp_ff.bin_index <= req_ff.func ? idx8_ff : 8'd0;
            rsp_ff.sum_out   <= 48'd0;
            rsp_ff.count_out <= 32'd0;
         end else if (req_ff.func || pv_neg) begin
            rsp_ff.status    <= req_ff.func ? whl_pkg::STATUS_READ : whl_pkg::STATUS_NEG_PROP;
            rsp_ff.bin_index <= idx8_ff;
            rsp_ff.sum_out   <= rd_sum_ff;
            rsp_ff.count_out <= rd_cnt_ff;
         end else begin
            rsp_ff.status    <= whl_pkg::STATUS_ACC;
            rsp_ff.bin_index <= idx8_ff;
            rsp_ff.sum_out   <= sum_new;
            rsp_ff.count_out <= cnt_new;
         end
      end
   end

   assign rsp_data = rsp_ff;

   assign stat.is_read  = req_ff.func;
   assign stat.log_mode = log_mode_ff;
   assign stat.bv_pos   = bv_pos;
   assign stat.bin_bad  = bad;
   assign stat.clr_last = clr_addr_ff == ADDR_W'(DEPTH - 1);

endmodule

>>> rtl/whl_ctrl.sv
// ----------------------------------------------------------------------------
// whl_ctrl: sequencing controller
// Walks one item through the datapath steps and owns both handshakes.
// ----------------------------------------------------------------------------
module whl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  whl_pkg::stat_type stat,
   output whl_pkg::cmd_type  cmd
);

   whl_pkg::state_type state_ff;
   whl_pkg::state_type state_in;
   logic [4:0]         step_ff;
   logic [4:0]         step_in;
   logic               rsp_valid_ff;
   logic               out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      step_in  = 5'd0;
      unique case (state_ff)
         whl_pkg::ST_CLEAR: if (stat.clr_last) state_in = whl_pkg::ST_IDLE;
         whl_pkg::ST_IDLE:  if (req_valid) state_in = whl_pkg::ST_DISP;
         whl_pkg::ST_DISP: begin
            if (stat.is_read) begin
               state_in = whl_pkg::ST_BIN;
            end else if (stat.log_mode) begin
               state_in = stat.bv_pos ? whl_pkg::ST_NORM : whl_pkg::ST_BIN;
            end else begin
               state_in = whl_pkg::ST_MBPM;
            end
         end
         whl_pkg::ST_NORM: begin
            step_in = step_ff + 5'd1;
            if (step_ff == whl_pkg::NORM_LAST) begin
               state_in = whl_pkg::ST_SQR;
               step_in  = 5'd0;
            end
         end
         whl_pkg::ST_SQR: begin
            step_in = step_ff + 5'd1;
            if (step_ff == whl_pkg::SQR_LAST) begin
               state_in = whl_pkg::ST_ML10;
               step_in  = 5'd0;
            end
         end
         whl_pkg::ST_ML10:  state_in = whl_pkg::ST_MBPM;
         whl_pkg::ST_MBPM:  state_in = whl_pkg::ST_BIN;
         whl_pkg::ST_BIN:   state_in = stat.bin_bad ? whl_pkg::ST_UPD : whl_pkg::ST_MEMRD;
         whl_pkg::ST_MEMRD: state_in = whl_pkg::ST_UPD;
         whl_pkg::ST_UPD:   if (out_free) state_in = whl_pkg::ST_IDLE;
         default:           state_in = whl_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd      = '0;
      cmd.step = step_ff;
      unique case (state_ff)
         whl_pkg::ST_CLEAR: cmd.clr_wr = 1'b1;
         whl_pkg::ST_IDLE:  cmd.load   = req_valid;
         whl_pkg::ST_NORM:  cmd.norm   = 1'b1;
         whl_pkg::ST_SQR:   cmd.sqr    = 1'b1;
         whl_pkg::ST_ML10: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = whl_pkg::MUL_L10;
         end
         whl_pkg::ST_MBPM: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = stat.log_mode ? whl_pkg::MUL_BPM_LOG : whl_pkg::MUL_BPM_LIN;
         end
         whl_pkg::ST_BIN: begin
            cmd.bin     = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = whl_pkg::MUL_WP;
         end
         whl_pkg::ST_MEMRD: cmd.mem_rd = 1'b1;
         whl_pkg::ST_UPD:   cmd.upd    = out_free;
         default:           cmd.step   = step_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= whl_pkg::ST_CLEAR;
         step_ff      <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (cmd.upd) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_stall = state_ff != whl_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> tb/weighted_log_histogram_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weighted_log_histogram_top_tb: self-checking bench of the weighted histogram
// Drives accumulate and read items under several register settings and idle
// patterns, predicts each result with a bit-accurate model of the binning,
// log10 and saturating store update, and compares every result in order.
// ----------------------------------------------------------------------------
module weighted_log_histogram_top_tb;

   localparam int MAXB   = 256;
   localparam int NSNAP  = 16;
   localparam int FRAC   = 16;
   localparam int DEPTH  = MAXB * NSNAP;
   localparam logic [47:0] SUM_SAT = 48'hFFFF_FFFF_FFFF;
   localparam longint CYCLE_LIMIT = 2_000_000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   whl_pkg::req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   whl_pkg::rsp_type rsp_data;
   logic    csr_we;
   logic [whl_pkg::CSR_IDX_W-1:0] csr_index;
   logic [whl_pkg::CSR_W-1:0]     csr_wdata;

   weighted_log_histogram_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow copy of the stores and registers
   logic [47:0] sum_mirror [DEPTH];
   logic [31:0] count_mirror [DEPTH];
   logic        mode_log;
   logic [10:0] bpm_reg;
   logic signed [15:0] min_reg;
   logic [8:0]  nbins_reg;

   whl_pkg::rsp_type expected_rsp [$];
   int      errors;
   int      n_checked;
   int      n_items;
   longint  cycles;
   int      send_idle_pct;
   int      stall_pct;
   int      hold_off;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run guard: a hang ends the run
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
         end
      end
   end

   function automatic longint floor_sh(longint v, int s);
      return v >>> s;
   endfunction

   // log2 of raw/2^FRAC in Q24, raw > 0
   function automatic longint log2_fixed(logic [31:0] raw);
      int msb;
      logic [63:0] m;
      longint fr;
      msb = 31;
      fr = 0;
      while (msb > 0 && raw[msb] == 1'b0) msb--;
      m = 64'(raw) << (30 - msb);
      for (int i = 0; i < 24; i++) begin
         m = (m * m) >> 30;
         fr = fr << 1;
         if (m >= 64'h8000_0000) begin
            fr = fr | 1;
            m = m >> 1;
         end
      end
      return longint'(msb - FRAC) * (longint'(1) << 24) + fr;
   endfunction

   // work out the histogram result of one item and update the shadow stores
   function automatic whl_pkg::rsp_type histogram_result(whl_pkg::req_type it);
      whl_pkg::rsp_type r;
      longint bv, pv, bpm, bin, l10;
      logic [63:0] w, inc, s, c;
      int idx;
      bv  = longint'(it.bin_value);
      pv  = longint'(it.prop_value);
      w   = 64'(it.weight);
      bpm = (bpm_reg == 0) ? 1 : longint'(bpm_reg);
      r = '0;
      if (it.func) begin
         idx = int'(it.read_bin) * NSNAP + int'(it.snap);
         r.status = whl_pkg::STATUS_READ;
         r.bin_index = it.read_bin;
         r.sum_out = sum_mirror[idx];
         r.count_out = count_mirror[idx];
         return r;
      end
      if (mode_log) begin
         if (bv <= 0) bin = 0;
         else begin
            l10 = floor_sh(log2_fixed(it.bin_value) * 1292913986, 32);
            bin = floor_sh(l10 * bpm, 24) - longint'(min_reg);
         end
         if (bin < 0) bin = 0;
      end else begin
         bin = floor_sh(bv * bpm, FRAC) - longint'(min_reg);
      end
      if (bin < 0 || bin >= longint'(nbins_reg) || bin >= MAXB) begin
         r.status = whl_pkg::STATUS_RANGE;
         return r;
      end
      idx = int'(bin) * NSNAP + int'(it.snap);
      r.bin_index = bin[7:0];
      if (pv < 0) begin
         r.status = whl_pkg::STATUS_NEG_PROP;
         r.sum_out = sum_mirror[idx];
         r.count_out = count_mirror[idx];
         return r;
      end
      inc = (w * 64'(pv)) >> FRAC;
      s = 64'(sum_mirror[idx]);
      c = 64'(count_mirror[idx]) + (w >> FRAC);
      if (inc > 64'(SUM_SAT) - s) s = 64'(SUM_SAT);
      else s = s + inc;
      if (c > 64'hFFFF_FFFF) c = 64'hFFFF_FFFF;
      sum_mirror[idx] = s[47:0];
      count_mirror[idx] = c[31:0];
      r.status = whl_pkg::STATUS_ACC;
      r.sum_out = s[47:0];
      r.count_out = c[31:0];
      return r;
   endfunction

   // result checker: compare each transfer against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            errors++;
         end else begin
            whl_pkg::rsp_type e;
            e = expected_rsp.pop_front();
            n_checked++;
            if (e.status !== rsp_data.status)
               $display("%0t: status expected %0d actual %0d",
                        $time, e.status, rsp_data.status);
            if (e.bin_index !== rsp_data.bin_index)
               $display("%0t: bin_index expected %0d actual %0d",
                        $time, e.bin_index, rsp_data.bin_index);
            if (e.sum_out !== rsp_data.sum_out)
               $display("%0t: sum_out expected %h actual %h",
                        $time, e.sum_out, rsp_data.sum_out);
            if (e.count_out !== rsp_data.count_out)
               $display("%0t: count_out expected %h actual %h",
                        $time, e.count_out, rsp_data.count_out);
            if (e !== rsp_data) errors++;
         end
      end
   end

   // receiver stall: random percentage, or a long counted hold-off
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (hold_off > 0) begin
         rsp_stall <= 1'b1;
         hold_off <= hold_off - 1;
      end else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // send one item: hold valid until the transfer, idle at random first;
   // valid stays up afterwards and drops at the next idle or drain
   task automatic send_item(whl_pkg::req_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsp.push_back(histogram_result(it));
      n_items++;
      @(negedge clock);
   endtask

   // wait for every result, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(logic [whl_pkg::CSR_IDX_W-1:0] idx,
                            logic [whl_pkg::CSR_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      case (idx)
         whl_pkg::CSR_LOG_MODE:     mode_log  = val[0];
         whl_pkg::CSR_BINS_PER_MAG: bpm_reg   = val[10:0];
         whl_pkg::CSR_MIN_INDEX:    min_reg   = val;
         default:                   nbins_reg = val[8:0];
      endcase
   endtask

   task automatic set_regs(logic lm, logic [10:0] bpm, logic [15:0] mi, logic [8:0] nb);
      drain();
      write_reg(whl_pkg::CSR_LOG_MODE, 16'(lm));
      write_reg(whl_pkg::CSR_BINS_PER_MAG, 16'(bpm));
      write_reg(whl_pkg::CSR_MIN_INDEX, mi);
      write_reg(whl_pkg::CSR_NUM_BINS, 16'(nb));
      csr_we <= 1'b0;
   endtask

   function automatic whl_pkg::req_type make_acc(logic [3:0] sn, logic [31:0] bv,
                                                 logic [31:0] pv, logic [31:0] w);
      whl_pkg::req_type it;
      it = '0;
      it.func = 1'b0;
      it.snap = sn;
      it.bin_value = bv;
      it.prop_value = pv;
      it.weight = w;
      it.read_bin = 8'($urandom);
      return it;
   endfunction

   function automatic whl_pkg::req_type make_read(logic [3:0] sn, logic [7:0] rb);
      whl_pkg::req_type it;
      it = make_acc(4'($urandom), $urandom, $urandom, $urandom);
      it.snap = sn;
      it.func = 1'b1;
      it.read_bin = rb;
      return it;
   endfunction

   // random item tuned so that most land in range for the current setting
   function automatic whl_pkg::req_type random_item();
      whl_pkg::req_type it;
      logic [31:0] bv;
      int k;
      k = $urandom_range(99);
      if (k < 25) return make_read(4'($urandom), 8'($urandom));
      case ($urandom_range(4))
         0: bv = $urandom;
         1: bv = $urandom_range(32'h0010_0000);
         2: bv = 32'($urandom_range(65535)) << $urandom_range(16);
         3: bv = -$urandom_range(65536 * 4);
         default: bv = $urandom_range(65536 * 40);
      endcase
      it = make_acc(4'($urandom), bv,
                    ($urandom_range(9) == 0) ? -$urandom_range(1000000) :
                    (($urandom_range(5) == 0) ? $urandom : $urandom_range(1 << 20)),
                    ($urandom_range(7) == 0) ? $urandom : $urandom_range(1 << 20));
      return it;
   endfunction

   task automatic run_random(int count);
      repeat (count) send_item(random_item());
   endtask

   // directed: extremes of fields, each status, special cases
   task automatic test_directed();
      send_idle_pct = 0;
      stall_pct = 0;
      send_item(make_read(4'd0, 8'd0));
      send_item(make_read(4'd15, 8'd255));
      send_item(make_acc(4'd0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
      send_item(make_acc(4'd0, 32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
      send_item(make_acc(4'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
      send_item(make_acc(4'd15, 32'h7FFF_FFFF, 32'h0002_0000, 32'h0003_8000));
      send_item(make_acc(4'd15, 32'h0000_0001, 32'h8000_0000, 32'h0001_0000));
      send_item(make_acc(4'd3, 32'h0064_0000, 32'hFFFF_FFFF, 32'h0000_0000));
      send_item(make_read(4'd0, 8'd0));
      // saturate one bin at the top
      repeat (3) send_item(make_acc(4'd1, 32'h0000_0000, 32'h7FFF_FFFF,
                                    32'hFFFF_FFFF));
      send_item(make_read(4'd1, 8'd0));
      // linear with bins_per_mag zero (counts as one), linear with min_index min, log with min_index max
      set_regs(1'b0, 11'd0, 16'sd5, 9'd256);
      send_item(make_acc(4'd2, 32'h0005_0000, 32'h0001_0000, 32'h0002_0000));
      send_item(make_acc(4'd2, 32'h0004_FFFF, 32'h0001_0000, 32'h0002_0000));
      send_item(make_acc(4'd2, 32'h0105_0000, 32'h0001_0000, 32'h0002_0000));
      set_regs(1'b0, 11'd1024, 16'h8000, 9'd1);
      send_item(make_acc(4'd4, 32'h8000_0000, 32'h0001_0000, 32'h0001_0000));
      send_item(make_acc(4'd4, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0001_0000));
      set_regs(1'b1, 11'd1024, 16'h7FFF, 9'd256);
      send_item(make_acc(4'd5, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0001_0000));
      send_item(make_acc(4'd5, 32'h0000_0001, 32'h0001_0000, 32'h0001_0000));
      send_item(make_read(4'd5, 8'd0));
   endtask

   // random phases across settings and idle patterns
   task automatic test_random();
      int pct [4] = '{0, 84, 0, 21};
      int spct [4] = '{0, 0, 84, 21};
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: set_regs(1'b1, 11'd10, 16'sd0, 9'd256);
            1: set_regs(1'b0, 11'd4, -16'sd32, 9'd200);
            2: set_regs(1'b1, 11'($urandom_range(1, 60)), 16'($urandom_range(0, 50) - 20),
                        9'($urandom_range(1, 256)));
            default: set_regs(1'b0, 11'($urandom_range(1, 1024)),
                              16'($urandom_range(0, 2000) - 1000), 9'($urandom_range(1, 256)));
         endcase
         send_idle_pct = pct[ph % 4];
         stall_pct = spct[ph % 4];
         run_random(195);
      end
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   // backpressure: receiver holds off while the sender keeps offering
   task automatic test_backpressure();
      set_regs(1'b0, 11'd8, 16'sd0, 9'd256);
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off = 300;
      run_random(60);
   endtask

   initial begin
      errors = 0;
      n_checked = 0;
      n_items = 0;
      hold_off = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_index = whl_pkg::CSR_LOG_MODE;
      csr_wdata = '0;
      for (int i = 0; i < DEPTH; i++) begin
         sum_mirror[i] = '0;
         count_mirror[i] = '0;
      end
      mode_log = 1'b1;
      bpm_reg = 11'd10;
      min_reg = 16'sd0;
      nbins_reg = 9'd256;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_backpressure();
      test_random();
      drain();
      $display("Covered %0d items and %0d checked results", n_items, n_checked);
      $display("over log and linear binning, saturation, range and idle phases");
      if (errors == 0 && expected_rsp.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
